[rtl/aes_pkg.sv]
// Package: AES-128 types, S-boxes and GF(2^8) helpers.
package aes_pkg;

	localparam int BlockBits = 128;
	localparam int KeyBits = 128;
	localparam int HalfBits = 64;

	typedef enum logic {
		CMD_ENC = 1'b0,
		CMD_DEC = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	typedef logic [BlockBits-1:0] block_t;
	typedef logic [KeyBits-1:0] key_t;

	typedef struct packed {
		logic   dec;
		block_t st;
		key_t   rk;
		logic [7:0] rc;
	} round_bus_t;

	function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] sbox_inv(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
		return t[a];
	endfunction

	function automatic logic [7:0] gf_dbl(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
	endfunction

	// byte i of the block sits at bits [127-8i -: 8]
	function automatic logic [7:0] byte_of(input block_t b, input int i);
		return b[BlockBits-1-8*i -: 8];
	endfunction

	function automatic block_t mix_fwd(input block_t s);
		block_t o;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = byte_of(s, 4*c);
			a1 = byte_of(s, 4*c+1);
			a2 = byte_of(s, 4*c+2);
			a3 = byte_of(s, 4*c+3);
			o[BlockBits-1-8*(4*c)   -: 8] = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
			o[BlockBits-1-8*(4*c+1) -: 8] = gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3 ^ a0;
			o[BlockBits-1-8*(4*c+2) -: 8] = gf_dbl(a2) ^ gf_dbl(a3) ^ a3 ^ a0 ^ a1;
			o[BlockBits-1-8*(4*c+3) -: 8] = gf_dbl(a3) ^ gf_dbl(a0) ^ a0 ^ a1 ^ a2;
		end
		return o;
	endfunction

	// inverse mix: pre-multiply by {04}x^2+{05}, then forward mix
	function automatic block_t mix_inv(input block_t s);
		block_t p;
		logic [7:0] u, v;
		for (int c = 0; c < 4; c++) begin
			u = gf_dbl(gf_dbl(byte_of(s, 4*c) ^ byte_of(s, 4*c+2)));
			v = gf_dbl(gf_dbl(byte_of(s, 4*c+1) ^ byte_of(s, 4*c+3)));
			p[BlockBits-1-8*(4*c)   -: 8] = byte_of(s, 4*c) ^ u;
			p[BlockBits-1-8*(4*c+1) -: 8] = byte_of(s, 4*c+1) ^ v;
			p[BlockBits-1-8*(4*c+2) -: 8] = byte_of(s, 4*c+2) ^ u;
			p[BlockBits-1-8*(4*c+3) -: 8] = byte_of(s, 4*c+3) ^ v;
		end
		return mix_fwd(p);
	endfunction

	function automatic block_t sub_shift_fwd(input block_t s);
		block_t o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[BlockBits-1-8*(4*c+r) -: 8] = sbox_fwd(byte_of(s, 4*((c+r)%4)+r));
		return o;
	endfunction

	function automatic block_t sub_shift_inv(input block_t s);
		block_t o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[BlockBits-1-8*(4*c+r) -: 8] = sbox_inv(byte_of(s, 4*((c+3*r)%4)+r));
		return o;
	endfunction

	// forward key step: round key i -> i+1 with round constant rc
	function automatic key_t key_next(input key_t k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		{w0, w1, w2, w3} = k;
		t = {sbox_fwd(w3[23:16]) ^ rc, sbox_fwd(w3[15:8]), sbox_fwd(w3[7:0]),
			sbox_fwd(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// backward key step: round key i+1 -> i, rc of that step
	function automatic key_t key_prev(input key_t k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, p3, t;
		{w0, w1, w2, w3} = k;
		p3 = w3 ^ w2;
		t = {sbox_fwd(p3[23:16]) ^ rc, sbox_fwd(p3[15:8]), sbox_fwd(p3[7:0]),
			sbox_fwd(p3[31:24])};
		return {w0 ^ t, w1 ^ w0, w2 ^ w1, p3};
	endfunction

	function automatic logic [7:0] gf_half(input logic [7:0] a);
		return a[0] ? ({1'b0, a[7:1]} ^ 8'h8D) : {1'b0, a[7:1]};
	endfunction

endpackage

[rtl/aes_stream_if.sv]
// Interface: valid/ready channel carrying an AES block transfer.
interface aes_stream_if import aes_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   command;
	logic [HalfBits-1:0] data_high;
	logic [HalfBits-1:0] data_low;

	modport source (output valid, command, data_high, data_low, input ready);
	modport sink (input valid, command, data_high, data_low, output ready);
endinterface

[rtl/aes_result_if.sv]
// Interface: valid/ready channel carrying an AES result transfer.
interface aes_result_if import aes_pkg::*; ();
	logic   valid;
	logic   ready;
	logic [HalfBits-1:0] result_high;
	logic [HalfBits-1:0] result_low;

	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface

[rtl/aes_round_cell.sv]
// Round cell: one AES round plus one key schedule step, registered.
module aes_round_cell import aes_pkg::*; #(
	parameter bit LAST = 1'b0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       vld_in,
	input  round_bus_t bus_in,
	output logic       vld_q,
	output round_bus_t bus_q
);
	block_t     enc_st, dec_st, mixed;
	key_t       nk;
	logic [7:0] nrc;
	round_bus_t nxt;

	always_comb begin
		nk     = bus_in.dec ? key_prev(bus_in.rk, bus_in.rc) : key_next(bus_in.rk, bus_in.rc);
		nrc    = bus_in.dec ? gf_half(bus_in.rc) : gf_dbl(bus_in.rc);
		mixed  = mix_fwd(sub_shift_fwd(bus_in.st));
		enc_st = (LAST ? sub_shift_fwd(bus_in.st) : mixed) ^ nk;
		dec_st = sub_shift_inv(bus_in.st) ^ nk;
		if (bus_in.dec && !LAST)
			dec_st = mix_inv(dec_st);
		nxt.dec = bus_in.dec;
		nxt.st  = bus_in.dec ? dec_st : enc_st;
		nxt.rk  = nk;
		nxt.rc  = nrc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_q <= nxt;
		end
	end
endmodule

[rtl/aes128_block_cipher.sv]
// Top level: AES-128 encrypt/decrypt, ten-cell unrolled round chain.
// Usage:
//   Write the key through cfg_we/cfg_index/cfg_data: index REG_KEY_HIGH holds
//   key bytes 0..7, REG_KEY_LOW bytes 8..15. Write only while idle.
//   Input channel s_in carries command (0 encrypt, 1 decrypt) and a block; a
//   transfer happens when valid and ready are high at a clock edge.
//   Output channel m_out carries the result block.
//   From input transfer to result valid a block passes the entry register,
//   loaded with the block xored with round key zero or ten at the transfer
//   edge, then the ten round cells. Throughput: one block per cycle while
//   m_out does not stall and no key setup runs; each cell holds a block and
//   its round key and hands both to the next cell each cycle it is enabled.
//   Decryption needs the last round key: it is kept in a register that is
//   recomputed from the key after each key write, during which s_in.ready
//   is low.
//   When m_out stalls the whole chain holds, so s_in.ready falls with it.
//   Reset clears the key to zero, empties the chain and starts the
//   last-round-key computation.
module aes128_block_cipher import aes_pkg::*; #(
	parameter int NUM_ROUNDS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [HalfBits-1:0] cfg_data,
	aes_stream_if.sink          s_in,
	aes_result_if.source        m_out
);
	localparam int CntW = $clog2(NUM_ROUNDS + 1);

	key_t            key_q, last_key_q, work_key_q;
	logic [7:0]      work_rc_q;
	logic [CntW-1:0] kcnt_q;
	logic            kbusy;
	logic            en;
	logic            vld [NUM_ROUNDS+1];
	round_bus_t      bus [NUM_ROUNDS+1];
	round_bus_t      entry;

	assign kbusy = (kcnt_q != CntW'(NUM_ROUNDS));
	assign en = !vld[NUM_ROUNDS] || m_out.ready;
	assign s_in.ready = en && !kbusy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			kcnt_q     <= '0;
			work_key_q <= '0;
			work_rc_q  <= 8'h01;
			last_key_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_HIGH)
				key_q[KeyBits-1 -: HalfBits] <= cfg_data;
			else
				key_q[HalfBits-1:0] <= cfg_data;
			kcnt_q    <= '0;
			work_rc_q <= 8'h01;
			if (cfg_index == REG_KEY_HIGH)
				work_key_q <= {cfg_data, key_q[HalfBits-1:0]};
			else
				work_key_q <= {key_q[KeyBits-1 -: HalfBits], cfg_data};
		end else if (kbusy) begin
			work_key_q <= key_next(work_key_q, work_rc_q);
			work_rc_q  <= gf_dbl(work_rc_q);
			kcnt_q     <= kcnt_q + CntW'(1);
			if (kcnt_q == CntW'(NUM_ROUNDS - 1))
				last_key_q <= key_next(work_key_q, work_rc_q);
		end
	end

	always_comb begin
		entry.dec = (s_in.command == CMD_DEC);
		entry.rk  = entry.dec ? last_key_q : key_q;
		entry.rc  = entry.dec ? 8'h36 : 8'h01;
		entry.st  = {s_in.data_high, s_in.data_low} ^ entry.rk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= s_in.valid && !kbusy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus[0] <= entry;
		end
	end

	for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
		aes_round_cell #(.LAST(g == NUM_ROUNDS - 1)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (vld[g]),
			.bus_in (bus[g]),
			.vld_q  (vld[g+1]),
			.bus_q  (bus[g+1])
		);
	end

	assign m_out.valid       = vld[NUM_ROUNDS];
	assign m_out.result_high = bus[NUM_ROUNDS].st[BlockBits-1 -: HalfBits];
	assign m_out.result_low  = bus[NUM_ROUNDS].st[HalfBits-1:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.result_high))
		else $error("result changed under stall");
	a_noacc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		kbusy |-> !s_in.ready)
		else $error("input taken during key setup");
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> kbusy)
		else $error("key write did not restart setup");
endmodule

[tb/tb_aes128_block_cipher.sv]
// Testbench: AES-128 block cipher checked against an in-bench cipher predictor.
module tb_aes128_block_cipher import aes_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		cmd_t        cmd;
		logic [63:0] hi;
		logic [63:0] lo;
	} block_req_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} block_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [63:0] cfg_data = '0;

	aes_stream_if s_in ();
	aes_result_if m_out ();

	aes128_block_cipher uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_in(s_in), .m_out(m_out)
	);

	always #5 clk = ~clk;

	block_req_t pending_blocks[$];
	block_res_t expected_blocks[$];
	logic [63:0] key_hi = '0, key_lo = '0;
	int errors = 0;
	int sent = 0, checked = 0, n_enc = 0, n_dec = 0;
	bit calm = 1'b0;
	bit hold_off = 1'b0;

	const logic [7:0] SBOX[256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

	function automatic logic [7:0] xtime(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = xtime(a);
		end
		return acc;
	endfunction

	function automatic block_res_t cipher_block(block_req_t q, logic [63:0] khi, logic [63:0] klo);
		logic [7:0] rk[176];
		logic [7:0] st[16];
		logic [7:0] tmp[16];
		logic [7:0] t[4];
		logic [7:0] a[4];
		logic [7:0] rc, f, inv[256];
		logic [7:0] m[4];
		block_res_t res;
		for (int i = 0; i < 256; i++) inv[SBOX[i]] = i[7:0];
		for (int i = 0; i < 8; i++) begin
			rk[i] = khi[63-8*i -: 8];
			rk[8+i] = klo[63-8*i -: 8];
			st[i] = q.hi[63-8*i -: 8];
			st[8+i] = q.lo[63-8*i -: 8];
		end
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++) t[j] = rk[(i-1)*4+j];
			if (i % 4 == 0) begin
				f = t[0];
				t[0] = SBOX[t[1]] ^ rc;
				t[1] = SBOX[t[2]];
				t[2] = SBOX[t[3]];
				t[3] = SBOX[f];
				rc = xtime(rc);
			end
			for (int j = 0; j < 4; j++) rk[i*4+j] = rk[(i-4)*4+j] ^ t[j];
		end
		if (q.cmd == CMD_ENC) m = '{8'h02, 8'h03, 8'h01, 8'h01};
		else m = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
		for (int i = 0; i < 16; i++) st[i] ^= rk[(q.cmd == CMD_ENC ? 0 : 160) + i];
		for (int k = 1; k <= 10; k++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					tmp[c*4+r] = (q.cmd == CMD_ENC) ? SBOX[st[((c+r)%4)*4+r]]
						: inv[st[((c+3*r)%4)*4+r]];
			st = tmp;
			if (q.cmd == CMD_DEC)
				for (int i = 0; i < 16; i++) st[i] ^= rk[(10-k)*16 + i];
			if (k < 10) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) a[r] = st[c*4+r];
					for (int r = 0; r < 4; r++)
						st[c*4+r] = gmul(a[r], m[0]) ^ gmul(a[(r+1)%4], m[1])
							^ gmul(a[(r+2)%4], m[2]) ^ gmul(a[(r+3)%4], m[3]);
				end
			end
			if (q.cmd == CMD_ENC)
				for (int i = 0; i < 16; i++) st[i] ^= rk[k*16 + i];
		end
		for (int i = 0; i < 8; i++) begin
			res.hi[63-8*i -: 8] = st[i];
			res.lo[63-8*i -: 8] = st[8+i];
		end
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic block_req_t make_req(cmd_t c, logic [63:0] h, logic [63:0] l);
		block_req_t q;
		q.cmd = c;
		q.hi = h;
		q.lo = l;
		return q;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_in.valid <= 1'b0;
			s_in.command <= CMD_ENC;
			s_in.data_high <= '0;
			s_in.data_low <= '0;
		end else begin
			if (s_in.valid && s_in.ready) begin
				expected_blocks.push_back(cipher_block(make_req(cmd_t'(s_in.command),
					s_in.data_high, s_in.data_low), key_hi, key_lo));
				sent++;
				if (s_in.command == CMD_ENC) n_enc++; else n_dec++;
			end
			if (!s_in.valid || s_in.ready) begin
				if (pending_blocks.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
					block_req_t q;
					q = pending_blocks.pop_front();
					s_in.valid <= 1'b1;
					s_in.command <= q.cmd;
					s_in.data_high <= q.hi;
					s_in.data_low <= q.lo;
				end else begin
					s_in.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_out.ready <= 1'b0;
		end else begin
			if (m_out.valid && m_out.ready) begin
				if (expected_blocks.size() == 0) begin
					$error("unexpected result transfer %h %h", m_out.result_high, m_out.result_low);
					errors++;
				end else begin
					block_res_t e;
					e = expected_blocks.pop_front();
					if (m_out.result_high !== e.hi) begin
						$error("result_high: expected %h, actual %h", e.hi, m_out.result_high);
						errors++;
					end
					if (m_out.result_low !== e.lo) begin
						$error("result_low: expected %h, actual %h", e.lo, m_out.result_low);
						errors++;
					end
					checked++;
				end
			end
			m_out.ready <= !hold_off && (calm || $urandom_range(99) >= 30);
		end
	end

	initial begin
		#20ms;
		$display("tb_aes128_block_cipher: done, errors");
		$finish;
	end

	task automatic drain();
		wait (pending_blocks.size() == 0);
		@(posedge clk);
		while (s_in.valid || expected_blocks.size() > 0) @(posedge clk);
		repeat (15) @(posedge clk);
	endtask

	task automatic write_key(reg_idx_t idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KEY_HIGH) key_hi = v; else key_lo = v;
		@(posedge clk);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			pending_blocks.push_back(make_req(cmd_t'($urandom_range(1)), rand64(), rand64()));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// zero key after reset
		pending_blocks.push_back(make_req(CMD_ENC, '0, '0));
		pending_blocks.push_back(make_req(CMD_DEC, '0, '0));
		drain();
		// FIPS-197 example key
		write_key(REG_KEY_HIGH, 64'h0001020304050607);
		write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		pending_blocks.push_back(make_req(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff));
		pending_blocks.push_back(make_req(CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a));
		pending_blocks.push_back(make_req(CMD_ENC, '1, '1));
		pending_blocks.push_back(make_req(CMD_DEC, '1, '1));
		pending_blocks.push_back(make_req(CMD_ENC, 64'h8000000000000000, 64'h1));
		pending_blocks.push_back(make_req(CMD_DEC, 64'h1, 64'h8000000000000000));
		drain();
		write_key(REG_KEY_HIGH, '1);
		write_key(REG_KEY_LOW, '1);
		pending_blocks.push_back(make_req(CMD_ENC, '0, '0));
		pending_blocks.push_back(make_req(CMD_DEC, '1, '0));
		drain();
		// back-pressure: receiver stalls while sender keeps offering
		calm = 1'b1;
		hold_off = 1'b1;
		random_phase(40);
		repeat (60) @(posedge clk);
		hold_off = 1'b0;
		drain();
		for (int p = 0; p < 8; p++) begin
			if (p == 3) write_key(REG_KEY_HIGH, '0);
			else write_key(REG_KEY_HIGH, rand64());
			write_key(REG_KEY_LOW, (p == 5) ? '1 : rand64());
			calm = (p == 2);
			random_phase(245);
			drain();
		end
		$display("covered %0d blocks (%0d encrypt, %0d decrypt), %0d results checked",
			sent, n_enc, n_dec, checked);
		$display("key settings: zero, all ones, FIPS example and random; long output stall");
		if (errors == 0) $display("tb_aes128_block_cipher: done, clean");
		else $display("tb_aes128_block_cipher: done, errors");
		$finish;
	end
endmodule

[sim.f]
rtl/aes_pkg.sv
rtl/aes_stream_if.sv
rtl/aes_result_if.sv
rtl/aes_round_cell.sv
rtl/aes128_block_cipher.sv
tb/tb_aes128_block_cipher.sv
